// File: src/box3_pkg.sv
// Shared types and constants for the 3x3 box filter stream core.
`default_nettype none

package box3_pkg;

  // Fixed field widths of the configuration and result interfaces.
  localparam int OUT_BITS        = 8;
  localparam int CFG_DATA_BITS   = 13;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int LINE_FIELD_BITS = 11;
  localparam int HEIGHT_BITS     = 13;
  localparam int ROW_BITS        = 12;

  // Frame geometry limits and reset values.
  localparam int MIN_DIM            = 3;
  localparam int MAX_HEIGHT         = 4096;
  localparam int RESET_LINE_WIDTH   = 640;
  localparam int RESET_FRAME_HEIGHT = 480;

  // Number of column cells in the window chain.
  localparam int WINDOW_COLS = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_WIDTH   = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Position flags that travel with each result.
  typedef struct packed {
    logic frame_last;
    logic row_last;
  } box3_flags_t;

endpackage

`default_nettype wire

// File: src/box3_line_store.sv
// One line store: a simple dual-port memory with a registered read.
`default_nettype none

module box3_line_store #(
  parameter int DEPTH      = 1024,
  parameter int DATA_BITS  = 8,
  parameter int ADDR_BITS  = 10
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [DATA_BITS-1:0] wr_data,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [0:DEPTH-1];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no read is requested.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/box3_col_cell.sv
// One column cell of the window chain: holds three pixels and their sum.
`default_nettype none

module box3_col_cell #(
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           shift,
  input  wire logic [2:0][PIXEL_BITS-1:0]     col_in,
  output logic      [2:0][PIXEL_BITS-1:0]     col_out,
  output logic      [PIXEL_BITS+1:0]          col_sum
);

  // Take the neighbor's column whenever a new pixel column enters the chain.
  always_ff @(posedge clk) begin
    if (shift) begin
      col_out <= col_in;
    end
  end

  // Sum of the top, middle and bottom pixels of this column.
  assign col_sum = (PIXEL_BITS+2)'(col_out[0]) + (PIXEL_BITS+2)'(col_out[1])
                 + (PIXEL_BITS+2)'(col_out[2]);

endmodule

`default_nettype wire

// File: src/box3_div9.sv
// Two-stage divide-by-nine unit that also serves as the output register.
`default_nettype none

module box3_div9
  import box3_pkg::*;
#(
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    advance,
  input  wire logic                    sum_valid,
  input  wire logic [PIXEL_BITS+3:0]   sum,
  input  wire box3_flags_t             sum_flags,
  output logic                         res_valid,
  output logic [OUT_BITS-1:0]          res_pixel,
  output box3_flags_t                  res_flags
);

  localparam int SUM_BITS = PIXEL_BITS + 4;
  localparam int SHIFT    = SUM_BITS;
  localparam logic [SUM_BITS-1:0] RECIP = SUM_BITS'((64'd1 << SHIFT) / 9);
  localparam logic [SUM_BITS-1:0] NINE  = SUM_BITS'(9);

  logic                    prod_valid;
  logic [2*SUM_BITS-1:0]   prod;
  logic [SUM_BITS-1:0]     prod_sum;
  box3_flags_t             prod_flags;

  logic [SUM_BITS-1:0]     quot_est;
  logic [SUM_BITS-1:0]     remainder;
  logic [SUM_BITS-1:0]     quot;

  // Stage one: multiply by the scaled reciprocal of nine.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (advance) begin
      prod_valid <= sum_valid;
    end
    if (advance) begin
      prod       <= (2*SUM_BITS)'(sum) * (2*SUM_BITS)'(RECIP);
      prod_sum   <= sum;
      prod_flags <= sum_flags;
    end
  end

  // The estimate is low by at most one; a single compare fixes it.
  always_comb begin
    quot_est  = prod[2*SUM_BITS-1:SHIFT];
    remainder = prod_sum - SUM_BITS'(quot_est * NINE);
    quot      = (remainder >= NINE) ? quot_est + SUM_BITS'(1) : quot_est;
  end

  // Stage two: output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= prod_valid;
    end
    if (advance) begin
      res_pixel <= OUT_BITS'(quot);
      res_flags <= prod_flags;
    end
  end

endmodule

`default_nettype wire

// File: src/box_filter_3x3_stream_core.sv
// Top level of the 3x3 box filter stream core.
`default_nettype none

// 3x3 box filter over a raster-order grayscale pixel stream. One pixel is
// accepted every clock cycle while out_stall is low; out_valid rises for a
// result once the pixel completing its window has passed the accept, window
// and sum stages and the two divider stages. Rows 0 and 1 and columns
// 0 and 1 of each frame give no result, so only full windows appear, each as
// the window sum divided by nine, truncated. The rate is set by the two line
// stores, which take one read and one write per cycle, and by a chain of
// three column cells that shifts once per pixel. Line width and frame height
// are clamped to their legal ranges on write; any write restarts the frame
// at the next pixel and must be made while the pipeline is empty. Line
// stores need no clearing after reset.
module box_filter_3x3_stream_core
  import box3_pkg::*;
#(
  parameter int MAX_LINE   = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [PIXEL_BITS-1:0]     pixel_in,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [OUT_BITS-1:0]            pixel_out,
  output logic                           frame_last,
  output logic                           row_last
);

  localparam int COL_BITS   = $clog2(MAX_LINE);
  localparam int WIDTH_BITS = $clog2(MAX_LINE + 1);
  localparam int RESET_W    = (RESET_LINE_WIDTH > MAX_LINE) ? MAX_LINE : RESET_LINE_WIDTH;
  localparam int SUM_BITS   = PIXEL_BITS + 4;

  logic                    advance;
  logic                    accept;

  logic [WIDTH_BITS-1:0]   line_w;
  logic [HEIGHT_BITS-1:0]  frame_h;
  logic [31:0]             w_wide;
  logic [31:0]             h_wide;

  logic [COL_BITS-1:0]     col_count;
  logic [ROW_BITS-1:0]     row_count;
  logic                    col_last;
  logic                    frame_row_last;

  logic                    b_valid;
  logic                    b_res;
  logic [COL_BITS-1:0]     b_addr;
  logic [PIXEL_BITS-1:0]   b_bot;
  box3_flags_t             b_flags;
  logic [PIXEL_BITS-1:0]   top_pix;
  logic [PIXEL_BITS-1:0]   mid_pix;
  logic                    cell_shift;

  logic [2:0][PIXEL_BITS-1:0] cell_col [0:WINDOW_COLS-1];
  logic [PIXEL_BITS+1:0]      cell_sum [0:WINDOW_COLS-1];

  logic                    c_valid;
  box3_flags_t             c_flags;
  logic                    s_valid;
  logic [SUM_BITS-1:0]     s_sum;
  box3_flags_t             s_flags;
  box3_flags_t             res_flags;

  // The whole pipeline moves when the output register is free or being taken.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  // Clamp incoming register values to their legal ranges.
  always_comb begin
    w_wide = 32'(cfg_data[LINE_FIELD_BITS-1:0]);
    if (w_wide < 32'(MIN_DIM)) begin
      w_wide = 32'(MIN_DIM);
    end else if (w_wide > 32'(MAX_LINE)) begin
      w_wide = 32'(MAX_LINE);
    end
    h_wide = 32'(cfg_data[HEIGHT_BITS-1:0]);
    if (h_wide < 32'(MIN_DIM)) begin
      h_wide = 32'(MIN_DIM);
    end else if (h_wide > 32'(MAX_HEIGHT)) begin
      h_wide = 32'(MAX_HEIGHT);
    end
  end

  // Position of the current pixel within its row and frame.
  assign col_last       = (WIDTH_BITS'(col_count) == line_w - WIDTH_BITS'(1));
  assign frame_row_last = ({1'b0, row_count} == frame_h - HEIGHT_BITS'(1));

  // Configuration registers and the raster counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_w    <= WIDTH_BITS'(RESET_W);
      frame_h   <= HEIGHT_BITS'(RESET_FRAME_HEIGHT);
      col_count <= '0;
      row_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_WIDTH:   line_w  <= WIDTH_BITS'(w_wide);
        REG_FRAME_HEIGHT: frame_h <= HEIGHT_BITS'(h_wide);
        default: ;
      endcase
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_last) begin
        col_count <= '0;
        row_count <= frame_row_last ? '0 : row_count + ROW_BITS'(1);
      end else begin
        col_count <= col_count + COL_BITS'(1);
      end
    end
  end

  // Accept stage: register the pixel and its position while the line stores read.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= accept;
    end
    if (accept) begin
      b_res              <= (row_count >= ROW_BITS'(2)) && (col_count >= COL_BITS'(2));
      b_addr             <= col_count;
      b_bot              <= pixel_in;
      b_flags.row_last   <= col_last;
      b_flags.frame_last <= col_last && frame_row_last;
    end
  end

  // Line stores: the upper row receives the middle row, the middle row the new pixel.
  assign cell_shift = advance && b_valid;

  box3_line_store #(
    .DEPTH     (MAX_LINE),
    .DATA_BITS (PIXEL_BITS),
    .ADDR_BITS (COL_BITS)
  ) u_upper_line (
    .clk     (clk),
    .wr_en   (cell_shift),
    .wr_addr (b_addr),
    .wr_data (mid_pix),
    .rd_en   (accept),
    .rd_addr (col_count),
    .rd_data (top_pix)
  );

  box3_line_store #(
    .DEPTH     (MAX_LINE),
    .DATA_BITS (PIXEL_BITS),
    .ADDR_BITS (COL_BITS)
  ) u_middle_line (
    .clk     (clk),
    .wr_en   (cell_shift),
    .wr_addr (b_addr),
    .wr_data (b_bot),
    .rd_en   (accept),
    .rd_addr (col_count),
    .rd_data (mid_pix)
  );

  // Chain of column cells: the newest column enters the first cell.
  generate
    for (genvar k = 0; k < WINDOW_COLS; k++) begin : g_cell
      if (k == 0) begin : g_head
        box3_col_cell #(
          .PIXEL_BITS (PIXEL_BITS)
        ) u_cell (
          .clk     (clk),
          .shift   (cell_shift),
          .col_in  ({top_pix, mid_pix, b_bot}),
          .col_out (cell_col[k]),
          .col_sum (cell_sum[k])
        );
      end else begin : g_body
        box3_col_cell #(
          .PIXEL_BITS (PIXEL_BITS)
        ) u_cell (
          .clk     (clk),
          .shift   (cell_shift),
          .col_in  (cell_col[k-1]),
          .col_out (cell_col[k]),
          .col_sum (cell_sum[k])
        );
      end
    end
  endgenerate

  // Window stage: track which requests carry a result through the cells.
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (advance) begin
      c_valid <= b_valid && b_res;
    end
    if (advance) begin
      c_flags <= b_flags;
    end
  end

  // Sum stage: add the three column sums of the window.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (advance) begin
      s_valid <= c_valid;
    end
    if (advance) begin
      s_sum   <= SUM_BITS'(cell_sum[0]) + SUM_BITS'(cell_sum[1]) + SUM_BITS'(cell_sum[2]);
      s_flags <= c_flags;
    end
  end

  // Divide by nine into the output register.
  box3_div9 #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_div9 (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .sum_valid (s_valid),
    .sum       (s_sum),
    .sum_flags (s_flags),
    .res_valid (out_valid),
    .res_pixel (pixel_out),
    .res_flags (res_flags)
  );

  assign frame_last = res_flags.frame_last;
  assign row_last   = res_flags.row_last;

endmodule

`default_nettype wire
